### rtl/mhdk_pkg.sv
// Shared types and constants for the monotone hull DP kernel.
`default_nettype none
package mhdk_pkg;

  localparam logic [1:0] CFG_QUAD  = 2'd0;
  localparam logic [1:0] CFG_LIN   = 2'd1;
  localparam logic [1:0] CFG_CONST = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_NS_M, S_NS_W, S_NI_M, S_NI_W,
    S_POP_CHK, S_POP_RJ, S_POP_RI, S_P1_M, S_P1_W, S_P2_M, S_P2_W,
    S_PUSH, S_Q_CHK, S_Q_R0, S_Q_R1, S_V0_M, S_V0_W, S_V1_M, S_V1_W,
    S_QF_R, S_QF_M, S_QF_W, S_T1_M, S_T1_W, S_T2_M, S_T2_W, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_NS, OP_NI, OP_LAT0, OP_LAT1, OP_P1, OP_POPCMP,
    OP_PUSH, OP_V0, OP_V1, OP_TAIL1, OP_DP, OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_LC1, RD_LC2, RD_QP, RD_QP1
  } rd_t;

  typedef enum logic [2:0] {
    MS_PA, MS_PT, MS_P1, MS_P2, MS_S0P, MS_S1P
  } msel_t;

  typedef struct packed {
    op_t   op;
    rd_t   rd;
    logic  mul_go;
    msel_t msel;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic pop_go;
    logic redundant;
    logic advance;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/mhdk_mul.sv
// Multi-cycle signed 64 by 64 multiplier with an exact 128-bit product.
`default_nettype none
module mhdk_mul (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [63:0]  op_x,
  input  wire logic [63:0]  op_y,
  output logic              done,
  output logic [127:0]      res
);

  logic [2:0]   step_r;
  logic         done_r;
  logic [63:0]  x_r, y_r, prod_r;
  logic         neg_r;
  logic [1:0]   pidx_r;
  logic [127:0] acc_r, res_r, shifted;
  logic [1:0]   k;
  logic [31:0]  xh, yh;

  assign k = 2'(step_r - 3'd2);
  assign xh = k[1] ? x_r[63:32] : x_r[31:0];
  assign yh = k[0] ? y_r[63:32] : y_r[31:0];

  always_comb begin
    unique case (pidx_r)
      2'd0:    shifted = {64'd0, prod_r};
      2'd3:    shifted = {prod_r, 64'd0};
      default: shifted = {32'd0, prod_r, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= (step_r == 3'd7);
      if (start) begin
        step_r <= 3'd1;
      end else if (step_r != 3'd0) begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= op_x;
      y_r <= op_y;
    end else if (step_r == 3'd1) begin
      neg_r <= x_r[63] ^ y_r[63];
      x_r   <= x_r[63] ? (64'd0 - x_r) : x_r;
      y_r   <= y_r[63] ? (64'd0 - y_r) : y_r;
      acc_r <= '0;
    end else begin
      if (step_r >= 3'd2 && step_r <= 3'd5) begin
        prod_r <= 64'(xh) * 64'(yh);
        pidx_r <= k;
      end
      if (step_r >= 3'd3 && step_r <= 3'd6) begin
        acc_r <= acc_r + shifted;
      end
      if (step_r == 3'd7) begin
        res_r <= neg_r ? (128'd0 - acc_r) : acc_r;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

### rtl/mhdk_ctrl.sv
// Sequencing state machine of the monotone hull DP kernel.
`default_nettype none
module mhdk_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mhdk_pkg::sts_t sts,
  output mhdk_pkg::cmd_t     cmd
);

  mhdk_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhdk_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mhdk_pkg::S_IDLE:    if (in_valid) state_nxt = mhdk_pkg::S_NS_M;
      mhdk_pkg::S_NS_M:    state_nxt = mhdk_pkg::S_NS_W;
      mhdk_pkg::S_NS_W:    if (sts.mul_done) state_nxt = mhdk_pkg::S_NI_M;
      mhdk_pkg::S_NI_M:    state_nxt = mhdk_pkg::S_NI_W;
      mhdk_pkg::S_NI_W:    if (sts.mul_done) state_nxt = mhdk_pkg::S_POP_CHK;
      mhdk_pkg::S_POP_CHK: state_nxt = sts.pop_go ? mhdk_pkg::S_POP_RJ : mhdk_pkg::S_PUSH;
      mhdk_pkg::S_POP_RJ:  state_nxt = mhdk_pkg::S_POP_RI;
      mhdk_pkg::S_POP_RI:  state_nxt = mhdk_pkg::S_P1_M;
      mhdk_pkg::S_P1_M:    state_nxt = mhdk_pkg::S_P1_W;
      mhdk_pkg::S_P1_W:    if (sts.mul_done) state_nxt = mhdk_pkg::S_P2_M;
      mhdk_pkg::S_P2_M:    state_nxt = mhdk_pkg::S_P2_W;
      mhdk_pkg::S_P2_W: begin
        if (sts.mul_done) begin
          state_nxt = sts.redundant ? mhdk_pkg::S_POP_CHK : mhdk_pkg::S_PUSH;
        end
      end
      mhdk_pkg::S_PUSH:    state_nxt = mhdk_pkg::S_Q_CHK;
      mhdk_pkg::S_Q_CHK:   state_nxt = sts.pop_go ? mhdk_pkg::S_Q_R0 : mhdk_pkg::S_QF_R;
      mhdk_pkg::S_Q_R0:    state_nxt = mhdk_pkg::S_Q_R1;
      mhdk_pkg::S_Q_R1:    state_nxt = mhdk_pkg::S_V0_M;
      mhdk_pkg::S_V0_M:    state_nxt = mhdk_pkg::S_V0_W;
      mhdk_pkg::S_V0_W:    if (sts.mul_done) state_nxt = mhdk_pkg::S_V1_M;
      mhdk_pkg::S_V1_M:    state_nxt = mhdk_pkg::S_V1_W;
      mhdk_pkg::S_V1_W: begin
        if (sts.mul_done) begin
          state_nxt = sts.advance ? mhdk_pkg::S_Q_CHK : mhdk_pkg::S_T1_M;
        end
      end
      mhdk_pkg::S_QF_R:    state_nxt = mhdk_pkg::S_QF_M;
      mhdk_pkg::S_QF_M:    state_nxt = mhdk_pkg::S_QF_W;
      mhdk_pkg::S_QF_W:    if (sts.mul_done) state_nxt = mhdk_pkg::S_T1_M;
      mhdk_pkg::S_T1_M:    state_nxt = mhdk_pkg::S_T1_W;
      mhdk_pkg::S_T1_W:    if (sts.mul_done) state_nxt = mhdk_pkg::S_T2_M;
      mhdk_pkg::S_T2_M:    state_nxt = mhdk_pkg::S_T2_W;
      mhdk_pkg::S_T2_W:    if (sts.mul_done) state_nxt = mhdk_pkg::S_OUT;
      mhdk_pkg::S_OUT:     if (sts.out_free) state_nxt = mhdk_pkg::S_IDLE;
      default:             state_nxt = mhdk_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.op     = mhdk_pkg::OP_NONE;
    cmd.rd     = mhdk_pkg::RD_NONE;
    cmd.mul_go = 1'b0;
    cmd.msel   = mhdk_pkg::MS_PA;
    unique case (state_r)
      mhdk_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = mhdk_pkg::OP_LOAD;
      end
      mhdk_pkg::S_NS_M: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = mhdk_pkg::MS_PA;
      end
      mhdk_pkg::S_NS_W: if (sts.mul_done) cmd.op = mhdk_pkg::OP_NS;
      mhdk_pkg::S_NI_M: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = mhdk_pkg::MS_PT;
      end
      mhdk_pkg::S_NI_W: if (sts.mul_done) cmd.op = mhdk_pkg::OP_NI;
      mhdk_pkg::S_POP_CHK: if (sts.pop_go) cmd.rd = mhdk_pkg::RD_LC1;
      mhdk_pkg::S_POP_RJ: begin
        cmd.op = mhdk_pkg::OP_LAT1;
        cmd.rd = mhdk_pkg::RD_LC2;
      end
      mhdk_pkg::S_POP_RI: cmd.op = mhdk_pkg::OP_LAT0;
      mhdk_pkg::S_P1_M: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = mhdk_pkg::MS_P1;
      end
      mhdk_pkg::S_P1_W: if (sts.mul_done) cmd.op = mhdk_pkg::OP_P1;
      mhdk_pkg::S_P2_M: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = mhdk_pkg::MS_P2;
      end
      mhdk_pkg::S_P2_W: if (sts.mul_done) cmd.op = mhdk_pkg::OP_POPCMP;
      mhdk_pkg::S_PUSH: cmd.op = mhdk_pkg::OP_PUSH;
      mhdk_pkg::S_Q_CHK: cmd.rd = mhdk_pkg::RD_QP;
      mhdk_pkg::S_Q_R0: begin
        cmd.op = mhdk_pkg::OP_LAT0;
        cmd.rd = mhdk_pkg::RD_QP1;
      end
      mhdk_pkg::S_Q_R1: cmd.op = mhdk_pkg::OP_LAT1;
      mhdk_pkg::S_V0_M, mhdk_pkg::S_QF_M: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = mhdk_pkg::MS_S0P;
      end
      mhdk_pkg::S_V0_W, mhdk_pkg::S_QF_W: if (sts.mul_done) cmd.op = mhdk_pkg::OP_V0;
      mhdk_pkg::S_V1_M: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = mhdk_pkg::MS_S1P;
      end
      mhdk_pkg::S_V1_W: if (sts.mul_done) cmd.op = mhdk_pkg::OP_V1;
      mhdk_pkg::S_QF_R: cmd.op = mhdk_pkg::OP_LAT0;
      mhdk_pkg::S_T1_M: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = mhdk_pkg::MS_PA;
      end
      mhdk_pkg::S_T1_W: if (sts.mul_done) cmd.op = mhdk_pkg::OP_TAIL1;
      mhdk_pkg::S_T2_M: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = mhdk_pkg::MS_PT;
      end
      mhdk_pkg::S_T2_W: if (sts.mul_done) cmd.op = mhdk_pkg::OP_DP;
      mhdk_pkg::S_OUT: if (sts.out_free) cmd.op = mhdk_pkg::OP_OUT;
      default: cmd.op = mhdk_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/mhdk_dpath.sv
// Datapath of the monotone hull DP kernel: registers, line store and multiplier.
`default_nettype none
module mhdk_dpath #(
  parameter int unsigned MAX_LINES = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mhdk_pkg::cmd_t cmd,
  output mhdk_pkg::sts_t      sts,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_addr,
  input  wire logic [31:0]    cfg_wdata,
  input  wire logic [15:0]    in_elem,
  input  wire logic           in_first,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [63:0]         out_dp,
  output logic                out_ovf
);

  localparam int unsigned AW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned LCW = AW + 1;

  logic signed [15:0] a_r;
  logic [31:0]  b_r, c_r;
  logic [15:0]  elem_r;
  logic [31:0]  pref_r;
  logic [63:0]  pdp_r, ns_r, ni_r, tmp_r, v0_r;
  logic [63:0]  s0_r, i0_r, s1_r, i1_r;
  logic [127:0] p1_r, rd_r;
  logic [LCW-1:0] lc_r;
  logic [AW-1:0]  qp_r;
  logic         ovf_r;
  logic         outv_r, outovf_r;
  logic [63:0]  outdp_r;

  logic [127:0] mem [MAX_LINES];

  logic [63:0]  a64, b64, c64, p64;
  logic [63:0]  mx, my, m_lo, v1, best, dp_new;
  logic [127:0] m_res;
  logic         m_done;
  logic [LCW-1:0] lc_m1, lc_m2, qp1;
  logic [AW-1:0]  raddr;
  logic         re;

  assign a64 = {{48{a_r[15]}}, a_r};
  assign b64 = {{32{b_r[31]}}, b_r};
  assign c64 = {{32{c_r[31]}}, c_r};
  assign p64 = {32'd0, pref_r};

  always_comb begin
    unique case (cmd.msel)
      mhdk_pkg::MS_PA:  begin mx = p64;           my = a64;           end
      mhdk_pkg::MS_PT:  begin mx = p64;           my = tmp_r;         end
      mhdk_pkg::MS_P1:  begin mx = i1_r - ni_r;   my = ns_r - s0_r;   end
      mhdk_pkg::MS_P2:  begin mx = ns_r - s1_r;   my = i0_r - ni_r;   end
      mhdk_pkg::MS_S0P: begin mx = s0_r;          my = p64;           end
      mhdk_pkg::MS_S1P: begin mx = s1_r;          my = p64;           end
      default:          begin mx = p64;           my = a64;           end
    endcase
  end

  mhdk_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_go),
    .op_x  (mx),
    .op_y  (my),
    .done  (m_done),
    .res   (m_res)
  );

  assign m_lo   = m_res[63:0];
  assign v1     = m_lo + i1_r;
  assign best   = v0_r[63] ? 64'd0 : v0_r;
  assign dp_new = best + m_lo + c64;

  assign lc_m1 = lc_r - LCW'(1);
  assign lc_m2 = lc_r - LCW'(2);
  assign qp1   = {1'b0, qp_r} + LCW'(1);

  always_comb begin
    re    = 1'b1;
    raddr = qp_r;
    unique case (cmd.rd)
      mhdk_pkg::RD_LC1: raddr = lc_m1[AW-1:0];
      mhdk_pkg::RD_LC2: raddr = lc_m2[AW-1:0];
      mhdk_pkg::RD_QP:  raddr = qp_r;
      mhdk_pkg::RD_QP1: raddr = qp1[AW-1:0];
      default:          re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == mhdk_pkg::OP_PUSH && lc_r < LCW'(MAX_LINES)) begin
      mem[lc_r[AW-1:0]] <= {ns_r, ni_r};
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  assign sts.mul_done  = m_done;
  assign sts.pop_go    = qp1 < lc_r;
  assign sts.redundant = $signed(p1_r) <= $signed(m_res);
  assign sts.advance   = $signed(v0_r) <= $signed(v1);
  assign sts.out_free  = !outv_r || out_ready;

  // Configuration and sequence state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r    <= '0;
      b_r    <= '0;
      c_r    <= '0;
      pref_r <= '0;
      pdp_r  <= '0;
      lc_r   <= '0;
      qp_r   <= '0;
      outv_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          mhdk_pkg::CFG_QUAD:  a_r <= cfg_wdata[15:0];
          mhdk_pkg::CFG_LIN:   b_r <= cfg_wdata;
          mhdk_pkg::CFG_CONST: c_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.op == mhdk_pkg::OP_LOAD && in_first) begin
        pref_r <= '0;
        pdp_r  <= '0;
        lc_r   <= '0;
        qp_r   <= '0;
      end
      if (cmd.op == mhdk_pkg::OP_POPCMP && sts.redundant) begin
        lc_r <= lc_m1;
      end
      if (cmd.op == mhdk_pkg::OP_PUSH) begin
        pref_r <= pref_r + 32'(elem_r);
        if (lc_r < LCW'(MAX_LINES)) lc_r <= lc_r + LCW'(1);
      end
      if (cmd.op == mhdk_pkg::OP_V1 && sts.advance) begin
        qp_r <= qp1[AW-1:0];
      end
      if (cmd.op == mhdk_pkg::OP_DP) begin
        pdp_r <= dp_new;
      end
      if (cmd.op == mhdk_pkg::OP_OUT) begin
        outv_r <= 1'b1;
      end else if (out_ready) begin
        outv_r <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      mhdk_pkg::OP_LOAD: begin
        elem_r <= in_elem;
        ovf_r  <= 1'b0;
      end
      mhdk_pkg::OP_NS: begin
        ns_r  <= 64'd0 - {m_lo[62:0], 1'b0};
        tmp_r <= m_lo - b64;
      end
      mhdk_pkg::OP_NI:    ni_r <= m_lo + pdp_r;
      mhdk_pkg::OP_LAT0:  begin s0_r <= rd_r[127:64]; i0_r <= rd_r[63:0]; end
      mhdk_pkg::OP_LAT1:  begin s1_r <= rd_r[127:64]; i1_r <= rd_r[63:0]; end
      mhdk_pkg::OP_P1:    p1_r <= m_res;
      mhdk_pkg::OP_PUSH:  if (!(lc_r < LCW'(MAX_LINES))) ovf_r <= 1'b1;
      mhdk_pkg::OP_V0:    v0_r <= m_lo + i0_r;
      mhdk_pkg::OP_TAIL1: tmp_r <= m_lo + b64;
      mhdk_pkg::OP_OUT: begin
        outdp_r  <= pdp_r;
        outovf_r <= ovf_r;
      end
      default: ;
    endcase
  end

  assign out_valid = outv_r;
  assign out_dp    = outdp_r;
  assign out_ovf   = outovf_r;

endmodule
`default_nettype wire

### rtl/monotone_hull_dp_kernel.sv
// Top level of the monotone convex-hull-trick DP kernel.
`default_nettype none
// Each accepted element value extends a running prefix sum and yields one
// result: the best partition score of the prefix so far. The block keeps a
// hull of lines in a line store of MAX_LINES entries; for each element the
// line built from the previous prefix sum and score is pushed after
// redundant lines are popped with an exact 128-bit cross-product test, and
// a monotone query pointer then walks forward to the best line. Setting the
// first flag on an element restarts the sequence. If the store is full after
// popping, the new line is dropped and the overflow flag of that result is
// set. All products go through one shared multi-cycle 64 by 64 multiplier.
// Each pop test and each pointer test adds two products to an item, and
// every popped line and every step of the query pointer adds one more
// test. The numbers of popped lines and pointer steps are amortised
// constant over a sequence. The result waits in its last state for as
// long as the output register still holds an earlier result that has not
// been taken. One item is worked on at a time; the next transfer is
// accepted while a finished result still waits in the output register.
// The coefficients are to be written through the cfg port only while the
// block is idle; the user is bound by this, the block does not enforce it.
module monotone_hull_dp_kernel #(
  parameter int unsigned MAX_LINES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] elem_value
  input  wire logic        in_tuser,   // [0] first
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] dp_value
  output logic             out_tuser   // [0] overflow
);

  mhdk_pkg::cmd_t cmd;
  mhdk_pkg::sts_t sts;

  // The controller sequences the micro-steps; the datapath owns all data state.
  mhdk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mhdk_dpath #(
    .MAX_LINES (MAX_LINES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_elem   (in_tdata),
    .in_first  (in_tuser),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_dp    (out_tdata),
    .out_ovf   (out_tuser)
  );

endmodule
`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the monotone hull DP kernel.
`timescale 1ns / 1ps

module tb_top;

  // Score tracker: a bit-accurate copy of the kernel's partition DP and a
  // queue of the scores still owed by the block.
  class hull_dp_tracker;
    typedef struct {
      logic [63:0] score;
      logic        dropped;
    } score_t;

    localparam int unsigned STORE_DEPTH = 1024;

    logic [63:0] quad, lin, cterm;
    logic [31:0] prefix;
    logic [63:0] last_score;
    logic [63:0] slope_mem [STORE_DEPTH];
    logic [63:0] icpt_mem  [STORE_DEPTH];
    int          hull_size;
    int          best_idx;
    score_t      owed_scores [$];
    int          errors;
    int          checked;
    int          drops;
    int          restarts;

    function new();
      quad = '0;
      lin = '0;
      cterm = '0;
      prefix = '0;
      last_score = '0;
      hull_size = 0;
      best_idx = 0;
      errors = 0;
      checked = 0;
      drops = 0;
      restarts = 0;
    endfunction

    function void set_coef(logic [1:0] idx, logic [31:0] val);
      if (idx == mhdk_pkg::CFG_QUAD) quad = {{48{val[15]}}, val[15:0]};
      else if (idx == mhdk_pkg::CFG_LIN) lin = {{32{val[31]}}, val};
      else if (idx == mhdk_pkg::CFG_CONST) cterm = {{32{val[31]}}, val};
    endfunction

    function logic signed [63:0] line_val(int k, logic [63:0] x);
      return $signed(slope_mem[k] * x + icpt_mem[k]);
    endfunction

    // Middle line j is useless between line i and the new line when the
    // exact 128-bit cross products say so.
    function bit is_useless(int i, int j, logic [63:0] ns, logic [63:0] ni);
      logic signed [63:0]  d1, d2, d3, d4;
      logic signed [127:0] p1, p2;
      d1 = icpt_mem[j] - ni;
      d2 = ns - slope_mem[i];
      d3 = ns - slope_mem[j];
      d4 = icpt_mem[i] - ni;
      p1 = d1 * d2;
      p2 = d3 * d4;
      return p1 <= p2;
    endfunction

    function void note_input(logic [15:0] elem, logic first);
      logic [63:0]        s, ns, ni, x, best, tail;
      logic signed [63:0] q;
      score_t             r;
      r.dropped = 1'b0;
      if (first) begin
        prefix = '0;
        last_score = '0;
        hull_size = 0;
        best_idx = 0;
        restarts++;
      end
      s = {32'd0, prefix};
      ns = 64'd0 - 64'd2 * quad * s;
      ni = s * (quad * s - lin) + last_score;
      while (best_idx + 1 < hull_size && is_useless(hull_size - 2, hull_size - 1, ns, ni))
        hull_size--;
      if (hull_size < STORE_DEPTH) begin
        slope_mem[hull_size] = ns;
        icpt_mem[hull_size] = ni;
        hull_size++;
      end else begin
        r.dropped = 1'b1;
        drops++;
      end
      prefix = prefix + {16'd0, elem};
      x = {32'd0, prefix};
      while (best_idx + 1 < hull_size && line_val(best_idx, x) <= line_val(best_idx + 1, x))
        best_idx++;
      q = line_val(best_idx, x);
      best = (q > 0) ? q : 64'd0;
      tail = x * (x * quad + lin) + cterm;
      last_score = best + tail;
      r.score = last_score;
      owed_scores.insert(owed_scores.size(), r);
    endfunction

    function void check_result(logic [63:0] score, logic dropped);
      score_t e;
      if (owed_scores.size() == 0) begin
        $error("unexpected result transfer: dp_value %0d", $signed(score));
        errors++;
        return;
      end
      e = owed_scores.pop_front();
      checked++;
      if (score !== e.score) begin
        $error("dp_value mismatch: expected %0d, actual %0d", $signed(e.score),
               $signed(score));
        errors++;
      end
      if (dropped !== e.dropped) begin
        $error("overflow mismatch: expected %0b, actual %0b", e.dropped, dropped);
        errors++;
      end
    endfunction

    function int owed();
      return owed_scores.size();
    endfunction
  endclass

  localparam int STALL_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] elem_value
  logic        in_tuser;   // [0] first
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [63:0] dp_value
  logic        out_tuser;  // [0] overflow

  hull_dp_tracker tracker;

  // Idle percentages for each side; the main sequence changes them between phases.
  int send_idle_pct;
  int recv_idle_pct;
  // Number of cycles for which the receiver is to refuse all results.
  int hold_cycles;
  int quiet_cycles;

  monotone_hull_dp_kernel dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver: random refusals, or a long hold when one is requested, so
  // that the result register fills and the block stops accepting input.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every result transfer is compared with the oldest owed score. Values
  // are read as they were just before the edge, so ordering cannot matter.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result(out_tdata, out_tuser);
  end

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", tracker.owed());
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_coef(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    tracker.set_coef(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] a, logic [31:0] b, logic [31:0] c);
    write_coef(mhdk_pkg::CFG_QUAD, {16'd0, a});
    write_coef(mhdk_pkg::CFG_LIN, b);
    write_coef(mhdk_pkg::CFG_CONST, c);
  endtask

  // One input transfer. Before offering, the sender idles cycle by cycle
  // with the current idle percentage. in_tvalid stays high on return so that
  // back-to-back transfers need no second assignment in the same time step.
  task automatic send_elem(logic [15:0] elem, logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= elem;
    in_tuser <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_input(elem, first);
  endtask

  // Lets the block finish everything owed before a coefficient change.
  task automatic drain();
    @(posedge clk);
    in_tvalid <= 1'b0;
    while (tracker.owed() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_elem();
    unique case ($urandom_range(3))
      0: return 16'($urandom_range(15));
      1: return 16'($urandom_range(255));
      2: return 16'hffff - 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n_items);
    for (int k = 0; k < n_items; k++)
      send_elem(rand_elem(), ($urandom_range(99) < 8) || (k == 0));
  endtask

  task automatic random_coefs();
    write_all(16'($urandom), $urandom, $urandom);
  endtask

  initial begin
    tracker = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part: the reset coefficients first, then ordinary and
    // extreme coefficient sets with extreme element values and restarts.
    send_elem(16'd0, 1'b0);
    send_elem(16'hffff, 1'b0);
    drain();
    write_all(16'd1, 32'd2, 32'd3);
    send_elem(16'd5, 1'b1);
    send_elem(16'd0, 1'b0);
    send_elem(16'd7, 1'b0);
    send_elem(16'hffff, 1'b0);
    send_elem(16'h5555, 1'b0);
    send_elem(16'haaaa, 1'b1);
    send_elem(16'd3, 1'b0);
    drain();
    write_all(16'h8000, 32'h8000_0000, 32'h7fff_ffff);
    send_elem(16'hffff, 1'b1);
    send_elem(16'hffff, 1'b0);
    send_elem(16'd1, 1'b0);
    send_elem(16'hffff, 1'b0);
    drain();
    write_all(16'h7fff, 32'h7fff_ffff, 32'h8000_0000);
    send_elem(16'hffff, 1'b1);
    send_elem(16'hffff, 1'b0);
    send_elem(16'd0, 1'b0);
    send_elem(16'd2, 1'b0);
    drain();

    // Random part, three idling regimes with fresh coefficients in between.
    write_all(16'hffff, 32'd100, 32'hffff_ff00);
    send_idle_pct = 32;
    recv_idle_pct = 78;
    random_phase(120);
    drain();
    random_coefs();
    send_idle_pct = 78;
    recv_idle_pct = 32;
    random_phase(120);
    drain();
    random_coefs();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(40);
    // Long receiver hold while the sender keeps offering items.
    hold_cycles = 400;
    random_phase(40);
    drain();
    write_all(16'd2, 32'hffff_fff0, 32'd0);
    random_phase(60);
    drain();

    // One long sequence in which every new line becomes the best one, so
    // the pointer steps every time and the line store only grows.
    write_all(16'd0, 32'd0, 32'd1);
    for (int k = 0; k < 100; k++)
      send_elem(16'($urandom_range(3, 1)), k == 0);

    drain();
    $display("covered %0d results with %0d restarts and %0d dropped lines",
             tracker.checked, tracker.restarts, tracker.drops);
    $display("directed extremes, three idling regimes, a long output hold, one long sequence");
    if (tracker.errors == 0 && tracker.owed() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
